>>> sv/sha1bsh_pkg.sv
package sha1bsh_pkg;

    typedef logic [4:0][31:0] chain_t;

    // Standard initial hash value, word 0 in the lowest slot.
    localparam chain_t SHA1_IV = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                                  32'hefcdab89, 32'h67452301};

    localparam logic [31:0] K_00_19 = 32'h5a827999;
    localparam logic [31:0] K_20_39 = 32'h6ed9eba1;
    localparam logic [31:0] K_40_59 = 32'h8f1bbcdc;
    localparam logic [31:0] K_60_79 = 32'hca62c1d6;

    localparam logic [6:0] LAST_ROUND = 7'd79;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [3:0] LEN_WORD   = 4'd14;
    localparam logic [2:0] LAST_DIGEST = 3'd4;

    typedef enum logic [1:0] {
        REQ_BYTE  = 2'd0,
        REQ_END   = 2'd1,
        REQ_START = 2'd2,
        REQ_RSVD  = 2'd3
    } req_t;

    // Control from the sequencer to the compression core.
    typedef struct packed {
        logic        init;
        logic        push;
        logic        go;
        logic [31:0] word;
    } core_ctl_t;

endpackage

>>> sv/sha1_byte_stream_hasher.sv
// SHA-1 hasher fed one request per transfer: add a byte, end the message, or start a new
// one. Every request returns one result transfer, except an accepted end, which returns the
// five digest words with last on the fifth. Requests are taken one at a time. A byte is
// accepted, then answered; every 64th byte also waits while the shared round unit runs 80
// rounds and the chaining add. An end feeds each padding and length byte (9 to 72) into the
// packer, waits for the round unit on each block this closes (one or two), then sends the
// digest words one per transfer, all held back while the output side stalls.
module sha1_byte_stream_hasher
    import sha1bsh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        accepted,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PAD80 = 7'b0000010,
        S_PADZ  = 7'b0000100,
        S_LEN   = 7'b0001000,
        S_CWAIT = 7'b0010000,
        S_RESP  = 7'b0100000,
        S_DIG   = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    state_t      ret_reg, ret_next;
    logic [23:0] partial_reg, partial_next;
    logic [1:0]  nbytes_reg, nbytes_next;
    logic [3:0]  nwords_reg, nwords_next;
    logic [63:0] bits_reg, bits_next;
    logic        finished_reg, finished_next;
    logic [2:0]  idx_reg, idx_next;
    logic        acc_reg, acc_next;

    logic        out_valid_reg, out_valid_next;
    logic        accepted_reg, accepted_next;
    logic [31:0] digest_word_reg, digest_word_next;
    logic [2:0]  word_index_reg, word_index_next;
    logic        last_reg, last_next;

    logic        ab_en;
    logic [7:0]  ab_byte;
    logic        ab_go;
    logic        out_free;
    logic [63:0] len_shift;
    core_ctl_t   core_ctl;
    logic        core_busy;
    chain_t      chain;

    sha1bsh_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (core_ctl),
        .busy  (core_busy),
        .chain (chain)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign ab_go     = (nbytes_reg == 2'd3) && (nwords_reg == 4'hf);
    assign len_shift = bits_reg >> {~idx_reg, 3'b000};

    always_comb
    begin
        state_next       = state_reg;
        ret_next         = ret_reg;
        partial_next     = partial_reg;
        nbytes_next      = nbytes_reg;
        nwords_next      = nwords_reg;
        bits_next        = bits_reg;
        finished_next    = finished_reg;
        idx_next         = idx_reg;
        acc_next         = acc_reg;
        out_valid_next   = out_valid_reg && out_stall;
        accepted_next    = accepted_reg;
        digest_word_next = digest_word_reg;
        word_index_next  = word_index_reg;
        last_next        = last_reg;
        ab_en            = 1'b0;
        ab_byte          = '0;
        core_ctl         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    priority if (req_type == REQ_START)
                    begin
                        partial_next  = '0;
                        nbytes_next   = '0;
                        nwords_next   = '0;
                        bits_next     = '0;
                        finished_next = 1'b0;
                        core_ctl.init = 1'b1;
                        acc_next      = 1'b1;
                        state_next    = S_RESP;
                    end
                    else if (req_type == REQ_RSVD || finished_reg)
                    begin
                        acc_next   = 1'b0;
                        state_next = S_RESP;
                    end
                    else if (req_type == REQ_BYTE)
                    begin
                        ab_en      = 1'b1;
                        ab_byte    = data_byte;
                        bits_next  = bits_reg + 64'd8;
                        acc_next   = 1'b1;
                        ret_next   = S_RESP;
                        state_next = ab_go ? S_CWAIT : S_RESP;
                    end
                    else
                    begin
                        acc_next   = 1'b1;
                        state_next = S_PAD80;
                    end
                end
            end
            S_PAD80:
            begin
                ab_en      = 1'b1;
                ab_byte    = PAD_BYTE;
                ret_next   = S_PADZ;
                state_next = ab_go ? S_CWAIT : S_PADZ;
            end
            S_PADZ:
            begin
                if (nwords_reg == LEN_WORD && nbytes_reg == 2'd0)
                begin
                    idx_next   = '0;
                    state_next = S_LEN;
                end
                else
                begin
                    ab_en    = 1'b1;
                    ret_next = S_PADZ;
                    if (ab_go)
                    begin
                        state_next = S_CWAIT;
                    end
                end
            end
            S_LEN:
            begin
                // Length goes out most significant byte first.
                ab_en    = 1'b1;
                ab_byte  = len_shift[7:0];
                idx_next = idx_reg + 3'd1;
                ret_next = (idx_reg == 3'd7) ? S_DIG : S_LEN;
                if (ab_go)
                begin
                    state_next = S_CWAIT;
                end
                else if (idx_reg == 3'd7)
                begin
                    state_next = S_DIG;
                end
            end
            S_CWAIT:
            begin
                if (!core_busy)
                begin
                    state_next = ret_reg;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    accepted_next    = acc_reg;
                    digest_word_next = '0;
                    word_index_next  = '0;
                    last_next        = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_DIG:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    accepted_next    = 1'b1;
                    digest_word_next = chain[idx_reg];
                    word_index_next  = idx_reg;
                    last_next        = (idx_reg == LAST_DIGEST);
                    if (idx_reg == LAST_DIGEST)
                    begin
                        idx_next      = '0;
                        finished_next = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Pack the byte; push each completed word into the core.
        if (ab_en)
        begin
            if (nbytes_reg != 2'd3)
            begin
                partial_next = {partial_reg[15:0], ab_byte};
                nbytes_next  = nbytes_reg + 2'd1;
            end
            else
            begin
                core_ctl.push = 1'b1;
                core_ctl.go   = ab_go;
                core_ctl.word = {partial_reg, ab_byte};
                partial_next  = '0;
                nbytes_next   = '0;
                nwords_next   = nwords_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            partial_reg   <= '0;
            nbytes_reg    <= '0;
            nwords_reg    <= '0;
            bits_reg      <= '0;
            finished_reg  <= 1'b0;
            idx_reg       <= '0;
            acc_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            partial_reg   <= partial_next;
            nbytes_reg    <= nbytes_next;
            nwords_reg    <= nwords_next;
            bits_reg      <= bits_next;
            finished_reg  <= finished_next;
            idx_reg       <= idx_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        accepted_reg    <= accepted_next;
        digest_word_reg <= digest_word_next;
        word_index_reg  <= word_index_next;
        last_reg        <= last_next;
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign accepted    = accepted_reg;
    assign digest_word = digest_word_reg;
    assign word_index  = word_index_reg;
    assign last        = last_reg;

endmodule

>>> sv/sha1bsh_core.sv
module sha1bsh_core
    import sha1bsh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  core_ctl_t ctl,
    output logic      busy,
    output chain_t    chain
);

    logic [31:0] window_reg [16];
    logic [31:0] window_next [16];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] a_next, b_next, c_next, d_next, e_next;
    logic [6:0]  round_reg, round_next;
    logic        rounds_reg, rounds_next;
    logic        add_reg, add_next;
    chain_t      chain_reg, chain_next;

    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] w_new;
    logic [31:0] w_mix;
    logic [31:0] tmp;

    always_comb
    begin
        priority if (round_reg < 7'd20)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K_00_19;
        end
        else if (round_reg < 7'd40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_20_39;
        end
        else if (round_reg < 7'd60)
        begin
            f_val = (b_reg & c_reg) ^ (b_reg & d_reg) ^ (c_reg & d_reg);
            k_val = K_40_59;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_60_79;
        end
    end

    assign w_mix = window_reg[13] ^ window_reg[8] ^ window_reg[2] ^ window_reg[0];
    assign w_new = {w_mix[30:0], w_mix[31]};
    assign tmp   = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + window_reg[0];

    always_comb
    begin
        window_next = window_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        d_next      = d_reg;
        e_next      = e_reg;
        round_next  = round_reg;
        rounds_next = rounds_reg;
        add_next    = 1'b0;
        chain_next  = chain_reg;

        if (ctl.init)
        begin
            chain_next = SHA1_IV;
        end
        else if (ctl.push)
        begin
            for (int i = 0; i < 15; i++)
            begin
                window_next[i] = window_reg[i + 1];
            end
            window_next[15] = ctl.word;
            if (ctl.go)
            begin
                rounds_next = 1'b1;
                round_next  = '0;
                a_next      = chain_reg[0];
                b_next      = chain_reg[1];
                c_next      = chain_reg[2];
                d_next      = chain_reg[3];
                e_next      = chain_reg[4];
            end
        end
        else if (rounds_reg)
        begin
            // Advance the schedule window by one word each round.
            for (int i = 0; i < 15; i++)
            begin
                window_next[i] = window_reg[i + 1];
            end
            window_next[15] = w_new;
            a_next = tmp;
            b_next = a_reg;
            c_next = {b_reg[1:0], b_reg[31:2]};
            d_next = c_reg;
            e_next = d_reg;
            round_next = round_reg + 7'd1;
            if (round_reg == LAST_ROUND)
            begin
                rounds_next = 1'b0;
                add_next    = 1'b1;
            end
        end
        else if (add_reg)
        begin
            chain_next[0] = chain_reg[0] + a_reg;
            chain_next[1] = chain_reg[1] + b_reg;
            chain_next[2] = chain_reg[2] + c_reg;
            chain_next[3] = chain_reg[3] + d_reg;
            chain_next[4] = chain_reg[4] + e_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_reg  <= '0;
            rounds_reg <= 1'b0;
            add_reg    <= 1'b0;
            chain_reg  <= SHA1_IV;
        end
        else
        begin
            round_reg  <= round_next;
            rounds_reg <= rounds_next;
            add_reg    <= add_next;
            chain_reg  <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        window_reg <= window_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        d_reg      <= d_next;
        e_reg      <= e_next;
    end

    assign busy  = rounds_reg | add_reg;
    assign chain = chain_reg;

endmodule

>>> tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sha1bsh_pkg::*;

    typedef struct packed {
        req_t       kind;
        logic [7:0] data;
    } request_t;

    typedef struct packed {
        logic        acc;
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_beat_t;

    localparam int RANDOM_ITEMS = 170;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type = REQ_BYTE;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        accepted;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;

    request_t     request_q[$];
    digest_beat_t expected_beats[$];
    digest_beat_t want_beat;
    int           error_count = 0;
    int           in_gap = 0;
    int           in_calm = 0;
    int           out_hold = 0;
    int           out_calm = 0;

    // Predictor state
    logic [31:0] hash_h[5];
    logic [31:0] blk[16];
    logic [23:0] part_word;
    logic [1:0]  part_cnt;
    logic [3:0]  word_cnt;
    logic [63:0] bit_count;
    logic        done_flag;

    sha1_byte_stream_hasher uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .accepted    (accepted),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last        (last)
    );

    always #5 clk = ~clk;

    task automatic note_error(input string msg);
        error_count++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Mostly short gaps, a few long, and now and then a run with none at all.
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 50);
    endfunction

    function automatic logic [31:0] rol(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    task automatic sha1_restart();
        for (int i = 0; i < 5; i++)
            hash_h[i] = SHA1_IV[i];
        for (int i = 0; i < 16; i++)
            blk[i] = '0;
        part_word = '0;
        part_cnt  = '0;
        word_cnt  = '0;
        bit_count = '0;
        done_flag = 1'b0;
    endtask

    task automatic sha1_compress();
        logic [31:0] w[80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
            w[i] = blk[i];
        for (int i = 16; i < 80; i++)
            w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = hash_h[0];
        b = hash_h[1];
        c = hash_h[2];
        d = hash_h[3];
        e = hash_h[4];
        for (int i = 0; i < 80; i++)
        begin
            if (i < 20)
            begin
                f = (b & c) | (~b & d);
                k = K_00_19;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d;
                k = K_20_39;
            end
            else if (i < 60)
            begin
                f = (b & c) ^ (b & d) ^ (c & d);
                k = K_40_59;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K_60_79;
            end
            t = rol(a, 5) + f + e + k + w[i];
            e = d;
            d = c;
            c = rol(b, 30);
            b = a;
            a = t;
        end
        hash_h[0] += a;
        hash_h[1] += b;
        hash_h[2] += c;
        hash_h[3] += d;
        hash_h[4] += e;
    endtask

    task automatic sha1_absorb(input logic [7:0] b);
        if (part_cnt < 2'd3)
        begin
            part_word = {part_word[15:0], b};
            part_cnt++;
        end
        else
        begin
            blk[word_cnt] = {part_word, b};
            part_word = '0;
            part_cnt  = '0;
            word_cnt++;
            if (word_cnt == 4'd0)
                sha1_compress();
        end
    endtask

    // Advance the hash state by one request and queue the beats it must produce.
    task automatic sha1_take_request(input request_t r);
        logic [63:0] len;
        if (r.kind == REQ_START)
        begin
            sha1_restart();
            expected_beats.push_back('{1'b1, 32'h0, 3'd0, 1'b1});
        end
        else if (r.kind == REQ_RSVD || done_flag)
            expected_beats.push_back('{1'b0, 32'h0, 3'd0, 1'b1});
        else if (r.kind == REQ_BYTE)
        begin
            sha1_absorb(r.data);
            bit_count += 64'd8;
            expected_beats.push_back('{1'b1, 32'h0, 3'd0, 1'b1});
        end
        else
        begin
            len = bit_count;
            sha1_absorb(PAD_BYTE);
            while ({word_cnt, part_cnt} != 6'd56)
                sha1_absorb(8'h00);
            for (int i = 0; i < 8; i++)
                sha1_absorb(len[63 - 8*i -: 8]);
            done_flag = 1'b1;
            for (int i = 0; i < 5; i++)
                expected_beats.push_back('{1'b1, hash_h[i], 3'(i), i == 4});
        end
    endtask

    task automatic add_req(input req_t k, input logic [7:0] d);
        request_q.push_back('{k, d});
    endtask

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            req_type  <= REQ_BYTE;
            data_byte <= 8'h00;
            in_gap = 0;
            sha1_restart();
        end
        else
        begin
            if (in_valid && !in_stall)
                sha1_take_request(request_q.pop_front());
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (request_q.size() > 0)
                begin
                    in_valid  <= 1'b1;
                    req_type  <= request_q[0].kind;
                    data_byte <= request_q[0].data;
                    in_gap = pick_gap(in_calm);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor and output stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_hold = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_beats.size() == 0)
                    note_error($sformatf("unexpected transfer acc=%0d word=%h idx=%0d last=%0d",
                                         accepted, digest_word, word_index, last));
                else
                begin
                    want_beat = expected_beats.pop_front();
                    if (accepted !== want_beat.acc)
                        note_error($sformatf("accepted %0d, want %0d",
                                             accepted, want_beat.acc));
                    if (digest_word !== want_beat.word)
                        note_error($sformatf("digest_word %h, want %h",
                                             digest_word, want_beat.word));
                    if (word_index !== want_beat.idx)
                        note_error($sformatf("word_index %0d, want %0d",
                                             word_index, want_beat.idx));
                    if (last !== want_beat.last)
                        note_error($sformatf("last %0d, want %0d", last, want_beat.last));
                end
            end
            if (out_hold > 0)
            begin
                out_hold--;
                out_stall <= 1'b1;
            end
            else
            begin
                if ($urandom_range(0, 3) == 0)
                    out_hold = pick_gap(out_calm);
                out_stall <= (out_hold > 0);
                if (out_hold > 0)
                    out_hold--;
            end
        end
    end

    initial
    begin
        int target;
        int len;
        int r;
        bit first_msg;

        // Empty message straight after reset, then requests after finish
        add_req(REQ_END, 8'hff);
        add_req(REQ_BYTE, 8'hff);
        add_req(REQ_END, 8'h00);
        add_req(REQ_RSVD, 8'hff);
        add_req(REQ_START, 8'h00);
        // Reserved type before finish must leave the message alone
        add_req(REQ_RSVD, 8'h5a);
        add_req(REQ_BYTE, 8'h00);
        add_req(REQ_BYTE, 8'hff);
        add_req(REQ_RSVD, 8'h00);
        add_req(REQ_BYTE, 8'h80);
        add_req(REQ_BYTE, 8'h7f);
        add_req(REQ_END, 8'h01);
        add_req(REQ_START, 8'hff);
        add_req(REQ_BYTE, 8'h61);
        add_req(REQ_BYTE, 8'h62);
        add_req(REQ_BYTE, 8'h63);
        // Start in the middle of a message drops it
        add_req(REQ_START, 8'h00);
        add_req(REQ_BYTE, 8'h61);
        add_req(REQ_BYTE, 8'h62);
        add_req(REQ_BYTE, 8'h63);
        add_req(REQ_END, 8'h00);
        add_req(REQ_START, 8'h00);

        target = RANDOM_ITEMS;
        first_msg = 1'b1;
        while (request_q.size() < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 85)
            begin
                if (first_msg)
                    len = $urandom_range(55, 63);   // from 56 bytes on, padding spills into a second block
                else
                begin
                    r = $urandom_range(0, 9);
                    if (r < 5)
                        len = $urandom_range(0, 9);
                    else if (r < 8)
                        len = $urandom_range(52, 65);
                    else
                        len = $urandom_range(10, 40);
                end
                first_msg = 1'b0;
                if ($urandom_range(0, 9) != 0)
                    add_req(REQ_START, 8'($urandom_range(0, 255)));
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 19) == 0)
                        add_req(REQ_RSVD, 8'($urandom_range(0, 255)));
                    add_req(REQ_BYTE, 8'($urandom_range(0, 255)));
                end
                add_req(REQ_END, 8'($urandom_range(0, 255)));
            end
            else
            begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                    add_req(req_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (request_q.size() != 0 || in_valid || expected_beats.size() != 0)
            @(posedge clk);
        // Hold a little longer to catch any stray transfer
        repeat (300) @(posedge clk);

        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #(5_000_000);
        $display("FAIL");
        $finish;
    end

endmodule
